@@ hdl/wsts_pkg.sv @@
// Shared types and constants for the work stealing thread scheduler.
// No dependencies; the front end, queue, back end, core and bench use this package.
package wsts_pkg;

    localparam int CPUS_DEF        = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int THREADS_DEF     = 32;

    localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_CPU_COUNT = 2'd0;
    localparam logic [1:0] REG_ONLINE    = 2'd1;
    localparam logic [1:0] REG_WORKER    = 2'd2;

    typedef enum logic [1:0] {
        FN_SUBMIT    = 2'd0,
        FN_SUBMIT_LL = 2'd1,
        FN_RESCHED   = 2'd2,
        FN_EXIT      = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_CPU  = 2'd1,
        ERR_SLOT = 2'd2,
        ERR_FULL = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        ST_FREE     = 3'd0,
        ST_READY    = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_EXITING  = 3'd3,
        ST_COMPLETE = 3'd4
    } t_slot_st;

    // classified command handed from the front end to the back end
    typedef struct packed {
        t_func       func;
        logic [2:0]  cpu;
        logic [63:0] value;
        logic        bad;     // cpu is zero or not below CPUS
        logic        online;
        logic        worker;
    } t_cmd;

    // configuration as seen by front and back end
    typedef struct packed {
        logic [3:0] cpu_count;
        logic [7:0] online;
        logic [7:0] worker;
        logic [7:0] rise;     // online bits going 0->1 at this write
    } t_cfg;

    typedef struct packed {
        logic        ok;
        t_err        err;
        logic [2:0]  chosen;
        logic [31:0] job;
        logic        idle;
        logic [4:0]  run_slot;
        logic [31:0] run_id;
        logic        stolen;
        logic [2:0]  victim;
        logic        retired;
        logic [31:0] retired_id;
        logic [63:0] retired_result;
    } t_res;

endpackage

@@ hdl/wsts_in_if.sv @@
// Command channel of the scheduler: valid/ready plus the command fields.
// No dependencies.
interface wsts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [2:0]  cpu;
    logic [63:0] result_value;

    modport source (output valid, func, cpu, result_value, input ready);
    modport sink   (input valid, func, cpu, result_value, output ready);
endinterface

@@ hdl/wsts_out_if.sv @@
// Result channel of the scheduler: valid/ready plus the result fields.
// No dependencies.
interface wsts_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [1:0]  error_code;
    logic [2:0]  chosen_cpu;
    logic [31:0] job_id;
    logic        idle;
    logic [4:0]  run_slot;
    logic [31:0] run_thread_id;
    logic        stolen;
    logic [2:0]  donor_cpu;
    logic        retired;
    logic [31:0] retired_id;
    logic [63:0] retired_result;

    modport source (output valid, ok, error_code, chosen_cpu, job_id, idle, run_slot,
                    run_thread_id, stolen, donor_cpu, retired, retired_id,
                    retired_result, input ready);
    modport sink   (input valid, ok, error_code, chosen_cpu, job_id, idle, run_slot,
                    run_thread_id, stolen, donor_cpu, retired, retired_id,
                    retired_result, output ready);
endinterface

@@ hdl/wsts_front.sv @@
// Front end: takes command beats and classifies the target CPU.
// Depends on wsts_pkg and wsts_in_if.
module wsts_front #(
    parameter int CPUS = wsts_pkg::CPUS_DEF
) (
    wsts_in_if.sink        i_cmd,
    input  wsts_pkg::t_cfg i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output wsts_pkg::t_cmd o_cmd
);

    logic in_rng;
    logic onl;

    assign i_cmd.ready = !i_q_full;
    assign o_push      = i_cmd.valid && !i_q_full;

    always_comb begin
        in_rng = (i_cmd.cpu != 3'd0) && (int'(i_cmd.cpu) < CPUS);
        onl    = in_rng && i_cfg.online[i_cmd.cpu];
        o_cmd.func   = wsts_pkg::t_func'(i_cmd.func);
        o_cmd.cpu    = i_cmd.cpu;
        o_cmd.value  = i_cmd.result_value;
        o_cmd.bad    = !in_rng;
        o_cmd.online = onl;
        o_cmd.worker = onl && ({1'b0, i_cmd.cpu} < i_cfg.cpu_count)
                       && i_cfg.worker[i_cmd.cpu];
    end

endmodule

@@ hdl/wsts_cmdq.sv @@
// Two-entry command queue between front end and back end.
// Depends on wsts_pkg.
module wsts_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsts_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output wsts_pkg::t_cmd o_cmd
);

    wsts_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_cmd;
                r_wp        <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ hdl/wsts_back.sv @@
// Back end: sequencer that runs one command against run queues and slot table,
// and the result register. Depends on wsts_pkg and wsts_out_if.
module wsts_back #(
    parameter int CPUS        = wsts_pkg::CPUS_DEF,
    parameter int QUEUE_DEPTH = wsts_pkg::QUEUE_DEPTH_DEF,
    parameter int THREADS     = wsts_pkg::THREADS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wsts_pkg::t_cfg i_cfg,
    input  logic           i_q_empty,
    input  wsts_pkg::t_cmd i_cmd,
    output logic           o_pop,
    wsts_out_if.source     o_res
);

    localparam int NQ  = (CPUS < 8) ? CPUS : 8;  // only CPUs below 8 can be online
    localparam int CIW = $clog2(NQ);
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = $clog2(THREADS);
    localparam int MD  = NQ * QUEUE_DEPTH;
    localparam int AW  = $clog2(MD);

    typedef enum logic [10:0] {
        S_IDLE  = 11'h001,
        S_DISP  = 11'h002,
        S_LOAD  = 11'h004,
        S_SCAN  = 11'h008,
        S_ALLOC = 11'h010,
        S_RS    = 11'h020,
        S_PRD   = 11'h040,
        S_PCHK  = 11'h080,
        S_STL   = 11'h100,
        S_RUN   = 11'h200,
        S_DONE  = 11'h400
    } t_state;

    t_state r_st;
    wsts_pkg::t_cmd r_cmd;
    wsts_pkg::t_res r_acc;
    wsts_pkg::t_res r_out;
    logic           r_ovld;

    logic [CIW-1:0] r_c;      // target / thief CPU
    logic [CIW-1:0] r_q;      // queue being popped
    logic [CIW-1:0] r_i;      // CPU scan index
    logic [CIW-1:0] r_sel;
    logic [FW:0]    r_best;
    logic [FW-1:0]  r_depth;
    logic [SW-1:0]  r_s;      // slot scan index, then slot picked to run
    logic           r_steal;
    logic [31:0]    r_next_id;

    logic [QW-1:0]  r_head  [NQ];
    logic [QW-1:0]  r_tail  [NQ];
    logic [FW-1:0]  r_fill  [NQ];
    logic           r_run_v [NQ];
    logic [SW-1:0]  r_run   [NQ];
    logic [63:0]    r_seq   [NQ];

    wsts_pkg::t_slot_st r_sst [THREADS];
    logic               r_squ [THREADS];
    logic [31:0]        r_sid [THREADS];
    logic [63:0]        r_sres [THREADS];
    logic [2:0]         r_srcpu [THREADS];
    logic [63:0]        r_smark [THREADS];

    logic [SW-1:0]  r_qmem [MD];
    logic [SW-1:0]  r_qrd;

    // combinational helpers
    logic [2:0]     ci3;
    logic           live_i;
    logic           wk_i;
    logic [FW:0]    ld;
    logic [CIW-1:0] ld_sel;
    logic [CIW-1:0] stl_sel;
    logic           last_i;
    logic [SW-1:0]  cur;
    logic           curv;
    logic           room;
    logic           rs_push;
    logic           q_we;
    logic [SW-1:0]  q_wdata;
    logic [AW-1:0]  q_waddr;
    logic [AW-1:0]  q_raddr;
    logic [QW-1:0]  tail_nx;
    logic [QW-1:0]  head_nx;
    logic           act;
    logic [2:0]     rc;
    logic           reuse;
    logic           out_free;
    logic [CIW-1:0] ccpu;

    always_comb begin
        ci3    = 3'(r_i);
        live_i = {1'b0, ci3} < i_cfg.cpu_count;
        wk_i   = i_cfg.online[ci3] && live_i && i_cfg.worker[ci3];
        ld     = {1'b0, r_fill[r_i]} + {{FW{1'b0}}, r_run_v[r_i]};
        ld_sel = (wk_i && ld < r_best) ? r_i : r_sel;
        stl_sel = (live_i && r_i != r_c && i_cfg.online[ci3] && r_fill[r_i] > r_depth)
                  ? r_i : r_sel;
        last_i = r_i == CIW'(NQ - 1);

        cur     = r_run[r_c];
        curv    = r_run_v[r_c];
        room    = r_fill[r_c] < FW'(QUEUE_DEPTH);
        rs_push = curv && r_sst[cur] == wsts_pkg::ST_RUNNING && room && !r_squ[cur];
        q_we    = (r_st == S_ALLOC && room) || (r_st == S_RS && rs_push);
        q_wdata = (r_st == S_ALLOC) ? r_s : cur;
        q_waddr = AW'(r_c) * AW'(QUEUE_DEPTH) + AW'(r_tail[r_c]);
        q_raddr = AW'(r_q) * AW'(QUEUE_DEPTH) + AW'(r_head[r_q]);
        tail_nx = (r_tail[r_c] == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail[r_c] + 1'b1;
        head_nx = (r_head[r_q] == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head[r_q] + 1'b1;

        // slot still held by a queue or by a live CPU
        act = r_squ[r_s];
        for (int c = 1; c < NQ; c++) begin
            if (4'(c) < i_cfg.cpu_count && r_run_v[c] && r_run[c] == r_s) begin
                act = 1'b1;
            end
        end
        rc    = r_srcpu[r_s];
        reuse = (r_sst[r_s] == wsts_pkg::ST_FREE)
                || (r_sst[r_s] == wsts_pkg::ST_COMPLETE && !act && int'(rc) < CPUS
                    && r_seq[CIW'(rc)] > r_smark[r_s]);

        out_free = !r_ovld || o_res.ready;
        o_pop    = r_st == S_IDLE && !i_q_empty;
        ccpu     = CIW'(r_cmd.cpu);
    end

    // run queue storage, registered read
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[q_waddr] <= q_wdata;
        end
        r_qrd <= r_qmem[q_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_ovld    <= 1'b0;
            r_next_id <= 32'd1;
            for (int c = 0; c < NQ; c++) begin
                r_head[c]  <= '0;
                r_tail[c]  <= '0;
                r_fill[c]  <= '0;
                r_run_v[c] <= 1'b0;
                r_seq[c]   <= '0;
            end
            for (int s = 0; s < THREADS; s++) begin
                r_sst[s] <= wsts_pkg::ST_FREE;
                r_squ[s] <= 1'b0;
            end
        end else begin
            if (r_st == S_DONE && out_free) begin
                r_ovld <= 1'b1;
                r_out  <= r_acc;
            end else if (o_res.ready) begin
                r_ovld <= 1'b0;
            end

            unique case (r_st)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd <= i_cmd;
                        r_acc <= '0;
                        r_st  <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_c   <= ccpu;
                    r_s   <= '0;
                    unique case (r_cmd.func)
                        wsts_pkg::FN_SUBMIT: begin
                            if (!r_cmd.worker) begin
                                r_acc.err <= wsts_pkg::ERR_CPU;
                                r_st      <= S_DONE;
                            end else begin
                                r_st <= S_SCAN;
                            end
                        end
                        wsts_pkg::FN_SUBMIT_LL: begin
                            r_i    <= CIW'(1);
                            r_sel  <= '0;
                            r_best <= '1;
                            r_st   <= S_LOAD;
                        end
                        default: begin
                            if (r_cmd.bad) begin
                                r_acc.err <= wsts_pkg::ERR_CPU;
                                r_st      <= S_DONE;
                            end else begin
                                if (r_cmd.func == wsts_pkg::FN_EXIT && r_run_v[ccpu]) begin
                                    r_sres[r_run[ccpu]] <= r_cmd.value;
                                    r_sst[r_run[ccpu]]  <= wsts_pkg::ST_EXITING;
                                    r_squ[r_run[ccpu]]  <= 1'b0;
                                end
                                if (!r_cmd.online) begin
                                    r_acc.err <= wsts_pkg::ERR_CPU;
                                    r_st      <= S_DONE;
                                end else begin
                                    r_st <= S_RS;
                                end
                            end
                        end
                    endcase
                end
                S_LOAD: begin
                    r_sel <= ld_sel;
                    if (wk_i && ld < r_best) begin
                        r_best <= ld;
                    end
                    r_i <= r_i + 1'b1;
                    if (last_i) begin
                        if (ld_sel == '0) begin
                            r_acc.err <= wsts_pkg::ERR_CPU;
                            r_st      <= S_DONE;
                        end else begin
                            r_c  <= ld_sel;
                            r_st <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (reuse) begin
                        r_st <= S_ALLOC;
                    end else if (r_s == SW'(THREADS - 1)) begin
                        r_acc.err <= wsts_pkg::ERR_SLOT;
                        r_st      <= S_DONE;
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                S_ALLOC: begin
                    // identifier is consumed even when the queue is full
                    if (r_next_id != wsts_pkg::ID_MAX) begin
                        r_next_id <= r_next_id + 32'd1;
                    end
                    r_sid[r_s] <= r_next_id;
                    if (room) begin
                        r_sst[r_s]    <= wsts_pkg::ST_READY;
                        r_squ[r_s]    <= 1'b1;
                        r_tail[r_c]   <= tail_nx;
                        r_fill[r_c]   <= r_fill[r_c] + 1'b1;
                        r_acc.ok      <= 1'b1;
                        r_acc.chosen  <= 3'(r_c);
                        r_acc.job     <= r_next_id;
                    end else begin
                        r_sst[r_s] <= wsts_pkg::ST_FREE;
                        r_squ[r_s] <= 1'b0;
                        r_acc.err  <= wsts_pkg::ERR_FULL;
                    end
                    r_st <= S_DONE;
                end
                S_RS: begin
                    r_seq[r_c] <= r_seq[r_c] + 64'd1;
                    r_q        <= r_c;
                    r_steal    <= 1'b0;
                    if (curv && r_sst[cur] == wsts_pkg::ST_RUNNING && !rs_push) begin
                        // requeue failed: thread keeps the CPU
                        r_acc.err      <= wsts_pkg::ERR_FULL;
                        r_acc.run_slot <= 5'(cur);
                        r_acc.run_id   <= r_sid[cur];
                        r_st           <= S_DONE;
                    end else begin
                        r_acc.ok   <= 1'b1;
                        r_run_v[r_c] <= 1'b0;
                        r_st       <= S_PRD;
                        if (rs_push) begin
                            r_sst[cur]  <= wsts_pkg::ST_READY;
                            r_squ[cur]  <= 1'b1;
                            r_tail[r_c] <= tail_nx;
                            r_fill[r_c] <= r_fill[r_c] + 1'b1;
                        end else if (curv && r_sst[cur] == wsts_pkg::ST_EXITING) begin
                            r_sst[cur]           <= wsts_pkg::ST_COMPLETE;
                            r_srcpu[cur]         <= 3'(r_c);
                            r_smark[cur]         <= r_seq[r_c] + 64'd1;
                            r_acc.retired        <= 1'b1;
                            r_acc.retired_id     <= r_sid[cur];
                            r_acc.retired_result <= r_sres[cur];
                        end
                    end
                end
                S_PRD: begin
                    if (r_fill[r_q] == '0) begin
                        if (!r_steal) begin
                            r_i     <= CIW'(1);
                            r_sel   <= '0;
                            r_depth <= FW'(1);
                            r_st    <= S_STL;
                        end else begin
                            r_acc.idle <= 1'b1;
                            r_st       <= S_DONE;
                        end
                    end else begin
                        r_head[r_q] <= head_nx;
                        r_fill[r_q] <= r_fill[r_q] - 1'b1;
                        r_st        <= S_PCHK;
                    end
                end
                S_PCHK: begin
                    r_squ[r_qrd] <= 1'b0;
                    if (r_sst[r_qrd] == wsts_pkg::ST_READY) begin
                        r_s  <= r_qrd;
                        r_st <= S_RUN;
                    end else begin
                        r_st <= S_PRD;   // stale entry, drop it
                    end
                end
                S_STL: begin
                    r_sel <= stl_sel;
                    if (stl_sel != r_sel) begin
                        r_depth <= r_fill[r_i];
                    end
                    r_i <= r_i + 1'b1;
                    if (last_i) begin
                        if (stl_sel == '0) begin
                            r_acc.idle <= 1'b1;
                            r_st       <= S_DONE;
                        end else begin
                            r_q     <= stl_sel;
                            r_steal <= 1'b1;
                            r_st    <= S_PRD;
                        end
                    end
                end
                S_RUN: begin
                    r_sst[r_s]     <= wsts_pkg::ST_RUNNING;
                    r_run[r_c]     <= r_s;
                    r_run_v[r_c]   <= 1'b1;
                    r_acc.run_slot <= 5'(r_s);
                    r_acc.run_id   <= r_sid[r_s];
                    r_acc.stolen   <= r_steal;
                    r_acc.victim   <= r_steal ? 3'(r_q) : 3'd0;
                    r_st           <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase

            // online 0->1 empties the queue and idles the CPU
            for (int c = 1; c < NQ; c++) begin
                if (i_cfg.rise[c]) begin
                    r_head[c]  <= '0;
                    r_tail[c]  <= '0;
                    r_fill[c]  <= '0;
                    r_run_v[c] <= 1'b0;
                end
            end
        end
    end

    assign o_res.valid          = r_ovld;
    assign o_res.ok             = r_out.ok;
    assign o_res.error_code     = r_out.err;
    assign o_res.chosen_cpu     = r_out.chosen;
    assign o_res.job_id         = r_out.job;
    assign o_res.idle           = r_out.idle;
    assign o_res.run_slot       = r_out.run_slot;
    assign o_res.run_thread_id  = r_out.run_id;
    assign o_res.stolen         = r_out.stolen;
    assign o_res.donor_cpu      = r_out.victim;
    assign o_res.retired        = r_out.retired;
    assign o_res.retired_id     = r_out.retired_id;
    assign o_res.retired_result = r_out.retired_result;

endmodule

@@ hdl/work_stealing_thread_scheduler_core.sv @@
// Work stealing thread scheduler: one command in flight in the back end.
// Submit: a slot reuse scan over up to THREADS slots, after a CPU scan for least loaded.
// Reschedule/exit: requeue or retire the running thread, pop entries (stale ones dropped)
// and steal-scan on an empty queue, then start the thread found; a stalled result waits.
// A two-beat command queue lets the front end take beats while the back end works.
// Synchronous active-low reset clears queues, slot states, ids and config; no clearing pass.
module work_stealing_thread_scheduler_core #(
    parameter int CPUS        = wsts_pkg::CPUS_DEF,
    parameter int QUEUE_DEPTH = wsts_pkg::QUEUE_DEPTH_DEF,
    parameter int THREADS     = wsts_pkg::THREADS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsts_in_if.sink     i_cmd,
    wsts_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0] r_cpu_count;
    logic [7:0] r_online;
    logic [7:0] r_worker;

    logic           wr;
    logic [1:0]     idx;
    wsts_pkg::t_cfg cfg;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    wsts_pkg::t_cmd f_cmd;
    wsts_pkg::t_cmd q_cmd;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_comb begin
        cfg.cpu_count = r_cpu_count;
        cfg.online    = r_online;
        cfg.worker    = r_worker;
        cfg.rise      = (wr && idx == wsts_pkg::REG_ONLINE) ? (pwdata[7:0] & ~r_online) : 8'd0;
        case (idx)
            wsts_pkg::REG_CPU_COUNT: prdata = {28'd0, r_cpu_count};
            wsts_pkg::REG_ONLINE:    prdata = {24'd0, r_online};
            wsts_pkg::REG_WORKER:    prdata = {24'd0, r_worker};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_count <= 4'd8;
            r_online    <= 8'd0;
            r_worker    <= 8'd0;
        end else if (wr) begin
            unique case (idx)
                wsts_pkg::REG_CPU_COUNT: r_cpu_count <= pwdata[3:0];
                wsts_pkg::REG_ONLINE:    r_online    <= pwdata[7:0];
                wsts_pkg::REG_WORKER:    r_worker    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    wsts_front #(.CPUS(CPUS)) u_front (
        .i_cmd    (i_cmd),
        .i_cfg    (cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (f_cmd)
    );

    wsts_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    wsts_back #(
        .CPUS        (CPUS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .THREADS     (THREADS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_cmd     (q_cmd),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |=> !q_empty)
        else $error("accepted beat missing from command queue");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty && !$past(q_pop && q_push == 1'b0 && q_empty))
        else $error("command queue popped while empty");

    a_stolen_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.stolen |-> o_res.ok && !o_res.idle)
        else $error("steal reported without a running thread");

endmodule

@@ bench/work_stealing_thread_scheduler_core_tb.sv @@
// Self-checking bench for work_stealing_thread_scheduler_core: a model of the run
// queues and slot table predicts each result. Depends on wsts_pkg, wsts_in_if, wsts_out_if.
`timescale 1ns / 1ps

class sched_scoreboard;
    localparam logic [5:0] NO_RUN = 6'h3F;

    logic [3:0]  cpu_cnt;
    logic [7:0]  online_bits;
    logic [7:0]  worker_bits;
    logic [4:0]  ring[8][16];
    logic [3:0]  head[8];
    logic [3:0]  tail[8];
    logic [4:0]  fill[8];
    logic [5:0]  running[8];
    logic [63:0] sched_cnt[8];
    wsts_pkg::t_slot_st status[32];
    logic        queued[32];
    logic [31:0] thread_id[32];
    logic [63:0] exit_value[32];
    logic [2:0]  exit_cpu[32];
    logic [63:0] exit_mark[32];
    logic [31:0] id_next;
    wsts_pkg::t_res expected[$];
    int          errors;

    function new();
        cpu_cnt = 4'd8;
        online_bits = '0;
        worker_bits = '0;
        id_next = 32'd1;
        errors = 0;
        for (int c = 0; c < 8; c++) begin
            head[c] = '0; tail[c] = '0; fill[c] = '0;
            running[c] = NO_RUN; sched_cnt[c] = '0;
            for (int e = 0; e < 16; e++) ring[c][e] = '0;
        end
        for (int s = 0; s < 32; s++) begin
            status[s] = wsts_pkg::ST_FREE; queued[s] = 1'b0; thread_id[s] = '0;
            exit_value[s] = '0; exit_cpu[s] = '0; exit_mark[s] = '0;
        end
    endfunction

    function int live();
        return (cpu_cnt < 8) ? int'(cpu_cnt) : 8;
    endfunction

    function bit is_on(int c);
        return c != 0 && online_bits[c];
    endfunction

    function bit is_worker(int c);
        return is_on(c) && c < live() && worker_bits[c];
    endfunction

    function void note_config(int idx, logic [31:0] val);
        logic [7:0] rise;
        if (idx == int'(wsts_pkg::REG_CPU_COUNT)) begin
            cpu_cnt = val[3:0];
        end else if (idx == int'(wsts_pkg::REG_ONLINE)) begin
            rise = val[7:0] & ~online_bits;
            online_bits = val[7:0];
            for (int c = 1; c < 8; c++) begin
                if (rise[c]) begin
                    head[c] = '0; tail[c] = '0; fill[c] = '0; running[c] = NO_RUN;
                end
            end
        end else if (idx == int'(wsts_pkg::REG_WORKER)) begin
            worker_bits = val[7:0];
        end
    endfunction

    function bit enqueue(int c, int s);
        if (!is_on(c) || fill[c] >= 16 || queued[s]) return 1'b0;
        ring[c][tail[c]] = s[4:0];
        tail[c]++;
        fill[c]++;
        queued[s] = 1'b1;
        return 1'b1;
    endfunction

    // pops until a ready slot comes out; stale entries are dropped
    function bit dequeue(int c, output int s);
        int v;
        s = 0;
        while (fill[c] > 0) begin
            v = ring[c][head[c]];
            head[c]++;
            fill[c]--;
            queued[v] = 1'b0;
            if (status[v] == wsts_pkg::ST_READY) begin
                s = v;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function bit steal_from(int thief, output int s, output int victim);
        int best;
        int depth;
        best = 0; depth = 1; s = 0; victim = 0;
        for (int c = 1; c < live(); c++) begin
            if (c == thief || !is_on(c)) continue;
            if (fill[c] > depth) begin
                best = c;
                depth = fill[c];
            end
        end
        if (best == 0 || !dequeue(best, s)) return 1'b0;
        victim = best;
        return 1'b1;
    endfunction

    function bit reusable(int s);
        if (status[s] == wsts_pkg::ST_FREE) return 1'b1;
        if (status[s] != wsts_pkg::ST_COMPLETE || queued[s]) return 1'b0;
        for (int c = 1; c < live(); c++)
            if (running[c] == s) return 1'b0;
        return sched_cnt[exit_cpu[s]] > exit_mark[s];
    endfunction

    function void submit(int c, ref wsts_pkg::t_res r);
        int s;
        logic [31:0] id;
        if (!is_worker(c)) begin
            r.err = wsts_pkg::ERR_CPU;
            return;
        end
        for (s = 0; s < 32; s++)
            if (reusable(s)) break;
        if (s >= 32) begin
            r.err = wsts_pkg::ERR_SLOT;
            return;
        end
        id = id_next;
        if (id_next != wsts_pkg::ID_MAX) id_next++;
        thread_id[s] = id;
        status[s] = wsts_pkg::ST_READY;
        queued[s] = 1'b0;
        exit_value[s] = '0;
        exit_cpu[s] = '0;
        exit_mark[s] = '0;
        if (!enqueue(c, s)) begin
            status[s] = wsts_pkg::ST_FREE;
            r.err = wsts_pkg::ERR_FULL;
            return;
        end
        r.ok = 1'b1;
        r.chosen = c[2:0];
        r.job = id;
    endfunction

    function void resched(int c, ref wsts_pkg::t_res r);
        int nxt;
        int victim;
        int cur;
        bit found;
        if (!is_on(c)) begin
            r.err = wsts_pkg::ERR_CPU;
            return;
        end
        sched_cnt[c]++;
        if (running[c] != NO_RUN) begin
            cur = running[c];
            if (status[cur] == wsts_pkg::ST_RUNNING) begin
                status[cur] = wsts_pkg::ST_READY;
                if (!enqueue(c, cur)) begin
                    // queue full: the thread stays on the cpu
                    status[cur] = wsts_pkg::ST_RUNNING;
                    r.err = wsts_pkg::ERR_FULL;
                    r.run_slot = cur[4:0];
                    r.run_id = thread_id[cur];
                    return;
                end
            end else if (status[cur] == wsts_pkg::ST_EXITING) begin
                status[cur] = wsts_pkg::ST_COMPLETE;
                exit_cpu[cur] = c[2:0];
                exit_mark[cur] = sched_cnt[c];
                r.retired = 1'b1;
                r.retired_id = thread_id[cur];
                r.retired_result = exit_value[cur];
            end
            running[c] = NO_RUN;
        end
        r.ok = 1'b1;
        found = dequeue(c, nxt);
        if (!found && steal_from(c, nxt, victim)) begin
            found = 1'b1;
            r.stolen = 1'b1;
            r.victim = victim[2:0];
        end
        if (found) begin
            status[nxt] = wsts_pkg::ST_RUNNING;
            running[c] = nxt[5:0];
            r.run_slot = nxt[4:0];
            r.run_id = thread_id[nxt];
        end else begin
            r.idle = 1'b1;
        end
    endfunction

    function void note_command(wsts_pkg::t_func fn, logic [2:0] cpu, logic [63:0] val);
        wsts_pkg::t_res r;
        int sel;
        int best;
        int load;
        int cur;
        r = '0;
        r.err = wsts_pkg::ERR_NONE;
        case (fn)
            wsts_pkg::FN_SUBMIT: begin
                submit(int'(cpu), r);
            end
            wsts_pkg::FN_SUBMIT_LL: begin
                sel = 0;
                best = 32'h7FFF_FFFF;
                for (int i = 1; i < live(); i++) begin
                    if (!is_worker(i)) continue;
                    load = fill[i] + ((running[i] != NO_RUN) ? 1 : 0);
                    if (load < best) begin
                        best = load;
                        sel = i;
                    end
                end
                if (sel == 0) r.err = wsts_pkg::ERR_CPU;
                else submit(sel, r);
            end
            default: begin
                if (cpu == 0) begin
                    r.err = wsts_pkg::ERR_CPU;
                end else begin
                    // exit marks the thread even when the cpu turns out offline
                    if (fn == wsts_pkg::FN_EXIT && running[cpu] != NO_RUN) begin
                        cur = running[cpu];
                        exit_value[cur] = val;
                        status[cur] = wsts_pkg::ST_EXITING;
                        queued[cur] = 1'b0;
                    end
                    resched(int'(cpu), r);
                end
            end
        endcase
        expected.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            errors++;
        end
    endfunction

    function void check_result(wsts_pkg::t_res got);
        wsts_pkg::t_res e;
        if (expected.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
            return;
        end
        e = expected.pop_front();
        cmp("ok", e.ok, got.ok);
        cmp("error_code", e.err, got.err);
        cmp("chosen_cpu", e.chosen, got.chosen);
        cmp("job_id", e.job, got.job);
        cmp("idle", e.idle, got.idle);
        cmp("run_slot", e.run_slot, got.run_slot);
        cmp("run_thread_id", e.run_id, got.run_id);
        cmp("stolen", e.stolen, got.stolen);
        cmp("donor_cpu", e.victim, got.victim);
        cmp("retired", e.retired, got.retired);
        cmp("retired_id", e.retired_id, got.retired_id);
        cmp("retired_result", e.retired_result, got.retired_result);
    endfunction
endclass

module work_stealing_thread_scheduler_core_tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    bit          calm = 1'b0;
    int          sent = 0;

    wsts_in_if  cmd_if ();
    wsts_out_if res_if ();

    sched_scoreboard sb = new();

    work_stealing_thread_scheduler_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        res_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
    end

    always @(posedge i_clk) begin
        wsts_pkg::t_res got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.ok = res_if.ok;
            got.err = wsts_pkg::t_err'(res_if.error_code);
            got.chosen = res_if.chosen_cpu;
            got.job = res_if.job_id;
            got.idle = res_if.idle;
            got.run_slot = res_if.run_slot;
            got.run_id = res_if.run_thread_id;
            got.stolen = res_if.stolen;
            got.victim = res_if.donor_cpu;
            got.retired = res_if.retired;
            got.retired_id = res_if.retired_id;
            got.retired_result = res_if.retired_result;
            sb.check_result(got);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.note_config(int'(idx), val);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // all results in before touching the registers
    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic set_cfg(logic [3:0] cnt, logic [7:0] onl, logic [7:0] wrk);
        settle();
        reg_write(wsts_pkg::REG_CPU_COUNT, {28'd0, cnt});
        reg_write(wsts_pkg::REG_ONLINE, {24'd0, onl});
        reg_write(wsts_pkg::REG_WORKER, {24'd0, wrk});
    endtask

    task automatic send_cmd(wsts_pkg::t_func fn, logic [2:0] cpu, logic [63:0] val);
        int gap;
        gap = (!calm && $urandom_range(99) < 23) ? $urandom_range(1, 4) : 0;
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.func <= fn;
        cmd_if.cpu <= cpu;
        cmd_if.result_value <= val;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sb.note_command(fn, cpu, val);
        sent++;
    endtask

    task automatic random_burst(int n);
        int pick;
        wsts_pkg::t_func fn;
        logic [2:0] cpu;
        for (int k = 0; k < n; k++) begin
            calm = (sent >= 400 && sent < 520);
            pick = $urandom_range(99);
            fn = (pick < 35) ? wsts_pkg::FN_SUBMIT : (pick < 55) ? wsts_pkg::FN_SUBMIT_LL :
                 (pick < 85) ? wsts_pkg::FN_RESCHED : wsts_pkg::FN_EXIT;
            cpu = ($urandom_range(99) < 85) ? 3'($urandom_range(1, 7))
                                            : 3'($urandom_range(0, 7));
            send_cmd(fn, cpu, {$urandom, $urandom});
        end
    endtask

    initial begin
        cmd_if.valid <= 1'b0;
        cmd_if.func <= wsts_pkg::FN_SUBMIT;
        cmd_if.cpu <= '0;
        cmd_if.result_value <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: nothing online, every command rejected
        send_cmd(wsts_pkg::FN_SUBMIT_LL, 3'd0, '0);
        send_cmd(wsts_pkg::FN_SUBMIT, 3'd1, '0);
        send_cmd(wsts_pkg::FN_RESCHED, 3'd0, '0);
        send_cmd(wsts_pkg::FN_EXIT, 3'd7, '1);

        // single worker: fill its queue, overflow, then full requeue on reschedule
        set_cfg(4'd8, 8'h06, 8'h02);
        send_cmd(wsts_pkg::FN_SUBMIT, 3'd0, '0);
        send_cmd(wsts_pkg::FN_SUBMIT, 3'd2, '0);
        for (int k = 0; k < 17; k++) send_cmd(wsts_pkg::FN_SUBMIT, 3'd1, '0);
        send_cmd(wsts_pkg::FN_RESCHED, 3'd1, '0);
        send_cmd(wsts_pkg::FN_SUBMIT_LL, 3'd0, '0);
        send_cmd(wsts_pkg::FN_RESCHED, 3'd1, '0);
        send_cmd(wsts_pkg::FN_EXIT, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_cmd(wsts_pkg::FN_RESCHED, 3'd2, '0);
        send_cmd(wsts_pkg::FN_EXIT, 3'd2, 64'h0123_4567_89AB_CDEF);

        set_cfg(4'd8, 8'hFE, 8'hFE);
        random_burst(120);
        set_cfg(4'd4, 8'hFF, 8'h0A);
        random_burst(110);
        set_cfg(4'd15, 8'h00, 8'hFF);
        set_cfg(4'd15, 8'hFF, 8'hFF);
        random_burst(120);
        set_cfg(4'd1, 8'h0F, 8'h0F);
        random_burst(60);
        set_cfg(4'd0, 8'hAA, 8'h55);
        random_burst(60);
        set_cfg(4'd8, 8'hFF, 8'hFC);
        random_burst(160);
        set_cfg(4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom));
        random_burst(80);
        set_cfg(4'd8, 8'h36, 8'hFF);
        random_burst(90);

        cmd_if.valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("work_stealing_thread_scheduler_core_tb: clean");
        end else begin
            $display("work_stealing_thread_scheduler_core_tb: errors");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("work_stealing_thread_scheduler_core_tb: errors");
        $finish;
    end
endmodule
